@@ hdl/pnmi_pkg.sv @@
// Shared types, constants and distance function for the palette nearest-match block
package pnmi_pkg;

  localparam int RGB_W     = 24;
  localparam int TAG_W     = 7;
  localparam int DIST_W    = 10;
  localparam int IDX_OUT_W = 8;
  localparam int ENTRY_W   = TAG_W + RGB_W;

  localparam logic [TAG_W-1:0]  TAG_FIRST = 7'd33;
  localparam logic [TAG_W-1:0]  TAG_QUOTE = 7'd34;
  localparam logic [TAG_W-1:0]  TAG_WRAP  = 7'd35;
  localparam logic [TAG_W:0]    TAG_LIMIT = 8'h7F;
  localparam logic [DIST_W-1:0] DIST_NONE = 10'd768;
  localparam logic [DIST_W-1:0] THRESH_RESET = 10'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE
  } pnmi_state_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } scan_ctl_t;

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [DIST_W-1:0] color_dist(input logic [RGB_W-1:0] x,
                                                  input logic [RGB_W-1:0] y);
    color_dist = DIST_W'(abs_diff(x[23:16], y[23:16]))
               + DIST_W'(abs_diff(x[15:8], y[15:8]))
               + DIST_W'(abs_diff(x[7:0], y[7:0]));
  endfunction

endpackage

@@ hdl/pnmi_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module pnmi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/pnmi_scan.sv @@
// Running nearest-entry tracker fed by palette memory read data
module pnmi_scan import pnmi_pkg::*; #(
  parameter int IDX_W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  scan_ctl_t          ctl,
  input  logic [IDX_W-1:0]   rd_idx,
  input  logic [ENTRY_W-1:0] rd_data,
  input  logic [RGB_W-1:0]   color,
  output logic [DIST_W-1:0]  best_dist,
  output logic [IDX_W-1:0]   best_idx,
  output logic [TAG_W-1:0]   best_tag
);

  logic [DIST_W-1:0] best_dist_r, best_dist_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [TAG_W-1:0]  best_tag_r, best_tag_nxt;
  logic [DIST_W-1:0] cur_dist;

  assign cur_dist = color_dist(color, rd_data[RGB_W-1:0]);

  always_comb begin
    best_dist_nxt = best_dist_r;
    best_idx_nxt  = best_idx_r;
    best_tag_nxt  = best_tag_r;
    if (ctl.clear) begin
      best_dist_nxt = DIST_NONE;
      best_idx_nxt  = '0;
    end else if (ctl.valid && (cur_dist < best_dist_r)) begin
      best_dist_nxt = cur_dist;
      best_idx_nxt  = rd_idx;
      best_tag_nxt  = rd_data[ENTRY_W-1:RGB_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_dist_r <= DIST_NONE;
      best_idx_r  <= '0;
    end else begin
      best_dist_r <= best_dist_nxt;
      best_idx_r  <= best_idx_nxt;
    end
    best_tag_r <= best_tag_nxt;
  end

  assign best_dist = best_dist_r;
  assign best_idx  = best_idx_r;
  assign best_tag  = best_tag_r;

  a_best_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    best_dist_r <= DIST_NONE)
    else $error("best distance above initial value");

  a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.clear |=> best_dist_r <= $past(best_dist_r))
    else $error("best distance grew without clear");

  a_clear_resets: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> best_dist_r == DIST_NONE && best_idx_r == '0)
    else $error("clear did not reset tracker");

endmodule

@@ hdl/palette_nearest_match_insert_top.sv @@
// Top level: palette nearest-match lookup with append, control and result register
//
//   channel  | handshake               | payload
//   ---------+-------------------------+---------------------------------------------
//   in       | in_valid / in_ready     | in_color_rgb[23:0]
//   out      | out_valid / out_ready   | out_entry_index, out_tag_char, out_distance,
//            |                         | out_exact_match, out_added, out_table_full
//   cfg      | cfg_wr_en               | cfg_wr_data[9:0] (match threshold)
//
// Each word runs from acceptance to result register in order: one palette memory
// read per stored entry, a wait for the last read data, the drain state, then the
// decide state that writes back; the next word is accepted once the block is idle
// again. The single palette memory read port sets this.
// Reset is synchronous; count, tag and threshold reset, memory contents do not.
// A new word is accepted while the previous result waits; decide holds while
// the result register is occupied and out_ready is low.
module palette_nearest_match_insert_top import pnmi_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [RGB_W-1:0]     in_color_rgb,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [IDX_OUT_W-1:0] out_entry_index,
  output logic [TAG_W-1:0]     out_tag_char,
  output logic [DIST_W-1:0]    out_distance,
  output logic                 out_exact_match,
  output logic                 out_added,
  output logic                 out_table_full,
  input  logic                 cfg_wr_en,
  input  logic [DIST_W-1:0]    cfg_wr_data
);

  localparam int IDX_W = $clog2(PALETTE_DEPTH);
  localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(PALETTE_DEPTH);

  pnmi_state_t state_r, state_nxt;

  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  scan_addr_r, scan_addr_nxt;
  logic [TAG_W-1:0]  next_tag_r, next_tag_nxt;
  logic [DIST_W-1:0] thresh_r;
  logic [RGB_W-1:0]  color_r;
  logic              rd_valid_r;
  logic [IDX_W-1:0]  rd_idx_r;

  logic                 out_valid_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic [TAG_W-1:0]     out_tag_r;
  logic [DIST_W-1:0]    out_dist_r;
  logic                 out_exact_r, out_added_r, out_full_r;

  logic              in_acc, rd_en, wr_en, out_free, out_load;
  logic              is_match, is_full, is_append;
  logic [TAG_W:0]    tag_inc;
  logic [ENTRY_W-1:0] rd_data;
  logic [DIST_W-1:0] best_dist;
  logic [IDX_W-1:0]  best_idx;
  logic [TAG_W-1:0]  best_tag;
  scan_ctl_t         scan_ctl;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign is_match  = (count_r != '0) && (best_dist <= thresh_r);
  assign is_full   = !is_match && (count_r == CNT_FULL);
  assign is_append = !is_match && !is_full;
  assign tag_inc   = {1'b0, next_tag_r} + 8'd1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_SCAN;
      ST_SCAN:   if (scan_addr_r == count_r) state_nxt = ST_DRAIN;
      ST_DRAIN:  state_nxt = ST_DECIDE;
      ST_DECIDE: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    rd_en         = 1'b0;
    wr_en         = 1'b0;
    out_load      = 1'b0;
    scan_addr_nxt = scan_addr_r;
    count_nxt     = count_r;
    next_tag_nxt  = next_tag_r;
    unique case (state_r)
      ST_IDLE: begin
        scan_addr_nxt = '0;
      end
      ST_SCAN: begin
        if (scan_addr_r != count_r) begin
          rd_en         = 1'b1;
          scan_addr_nxt = scan_addr_r + 1'b1;
        end
      end
      ST_DRAIN: begin
      end
      ST_DECIDE: begin
        if (out_free) begin
          out_load = 1'b1;
          if (is_append) begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
            if (tag_inc >= TAG_LIMIT || tag_inc[TAG_W-1:0] == TAG_QUOTE) begin
              next_tag_nxt = TAG_WRAP;
            end else begin
              next_tag_nxt = tag_inc[TAG_W-1:0];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      next_tag_r  <= TAG_FIRST;
      thresh_r    <= THRESH_RESET;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      scan_addr_r <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      next_tag_r  <= next_tag_nxt;
      rd_valid_r  <= rd_en;
      scan_addr_r <= scan_addr_nxt;
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      color_r <= in_color_rgb;
    end
    rd_idx_r <= scan_addr_r[IDX_W-1:0];
    if (out_load) begin
      if (is_append) begin
        out_idx_r   <= IDX_OUT_W'(count_r);
        out_tag_r   <= next_tag_r;
        out_dist_r  <= '0;
        out_exact_r <= 1'b0;
        out_added_r <= 1'b1;
        out_full_r  <= 1'b0;
      end else begin
        out_idx_r   <= IDX_OUT_W'(best_idx);
        out_tag_r   <= best_tag;
        out_dist_r  <= best_dist;
        out_exact_r <= is_match && (best_dist == '0);
        out_added_r <= 1'b0;
        out_full_r  <= is_full;
      end
    end
  end

  assign scan_ctl.clear = in_acc;
  assign scan_ctl.valid = rd_valid_r;

  pnmi_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data ({next_tag_r, color_r}),
    .rd_en   (rd_en),
    .rd_addr (scan_addr_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  pnmi_scan #(
    .IDX_W (IDX_W)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .rd_idx    (rd_idx_r),
    .rd_data   (rd_data),
    .color     (color_r),
    .best_dist (best_dist),
    .best_idx  (best_idx),
    .best_tag  (best_tag)
  );

  assign out_valid       = out_valid_r;
  assign out_entry_index = out_idx_r;
  assign out_tag_char    = out_tag_r;
  assign out_distance    = out_dist_r;
  assign out_exact_match = out_exact_r;
  assign out_added       = out_added_r;
  assign out_table_full  = out_full_r;

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("entry count above palette depth");

  a_tag_legal: assert property (@(posedge clk) disable iff (!rst_n)
    next_tag_r != TAG_QUOTE && next_tag_r >= TAG_FIRST && {1'b0, next_tag_r} < TAG_LIMIT)
    else $error("next tag out of range");

  a_append_counts: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> count_r == $past(count_r) + 1'b1)
    else $error("append did not advance count");

  a_no_read_in_decide: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !rd_en && !rd_valid_r && state_r == ST_DECIDE)
    else $error("write overlaps scan");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> scan_addr_r < count_r)
    else $error("read beyond stored entries");

endmodule

@@ tb/sv/palette_match_checker.sv @@
// Checker: predicts palette lookup results from observed traffic and compares each output word
module palette_match_checker import pnmi_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [RGB_W-1:0]     in_color_rgb,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [IDX_OUT_W-1:0] out_entry_index,
  input  logic [TAG_W-1:0]     out_tag_char,
  input  logic [DIST_W-1:0]    out_distance,
  input  logic                 out_exact_match,
  input  logic                 out_added,
  input  logic                 out_table_full,
  input  logic                 cfg_wr_en,
  input  logic [DIST_W-1:0]    cfg_wr_data,
  output int                   mismatch_count,
  output int                   pending,
  output int                   words_checked,
  output int                   appended_count,
  output int                   exact_count,
  output int                   full_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] index;
    logic [TAG_W-1:0]     tag;
    logic [DIST_W-1:0]    dist_sum;
    logic                 exact;
    logic                 added;
    logic                 full;
  } match_word_t;

  logic [RGB_W-1:0]  pal_rgb [PALETTE_DEPTH];
  logic [TAG_W-1:0]  pal_tag [PALETTE_DEPTH];
  int                stored;
  logic [TAG_W-1:0]  tag_next;
  logic [DIST_W-1:0] threshold;
  match_word_t       expected_words[$];

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t ns: mismatch on %s after %0d words: expected %0d, got %0d",
             $realtime, what, words_checked, want, got);
    mismatch_count++;
  endtask

  function automatic int chan_gap(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  task automatic predict_lookup(input logic [RGB_W-1:0] rgb, output match_word_t w);
    int   best_dist;
    int   best_slot;
    int   d;
    int   slot;
    logic found;
    logic [TAG_W:0] bumped;
    best_dist = int'(DIST_NONE);
    best_slot = 0;
    found = 1'b0;
    w = '0;
    for (slot = 0; slot < stored && !found; slot++) begin
      d = chan_gap(rgb[23:16], pal_rgb[slot][23:16])
        + chan_gap(rgb[15:8], pal_rgb[slot][15:8])
        + chan_gap(rgb[7:0], pal_rgb[slot][7:0]);
      if (d == 0) begin
        found = 1'b1;
        w.index = IDX_OUT_W'(slot);
        w.tag = pal_tag[slot];
        w.exact = 1'b1;
      end else if (d < best_dist) begin
        best_dist = d;
        best_slot = slot;
      end
    end
    if (!found) begin
      if (stored > 0 && best_dist <= int'(threshold)) begin
        w.index = IDX_OUT_W'(best_slot);
        w.tag = pal_tag[best_slot];
        w.dist_sum = DIST_W'(best_dist);
      end else if (stored >= PALETTE_DEPTH) begin
        w.index = IDX_OUT_W'(best_slot);
        w.tag = pal_tag[best_slot];
        w.dist_sum = DIST_W'(best_dist);
        w.full = 1'b1;
      end else begin
        pal_rgb[stored] = rgb;
        pal_tag[stored] = tag_next;
        w.index = IDX_OUT_W'(stored);
        w.tag = tag_next;
        w.added = 1'b1;
        stored++;
        bumped = {1'b0, tag_next} + 1'b1;
        if (bumped >= TAG_LIMIT || bumped[TAG_W-1:0] == TAG_QUOTE) begin
          tag_next = TAG_WRAP;
        end else begin
          tag_next = bumped[TAG_W-1:0];
        end
      end
    end
  endtask

  always @(posedge clk) begin
    match_word_t want;
    match_word_t got;
    if (!rst_n) begin
      stored = 0;
      tag_next = TAG_FIRST;
      threshold = THRESH_RESET;
      expected_words.delete();
      mismatch_count = 0;
      words_checked = 0;
      appended_count = 0;
      exact_count = 0;
      full_count = 0;
    end else begin
      if (cfg_wr_en) begin
        threshold = cfg_wr_data;
      end
      if (out_valid && out_ready) begin
        got = {out_entry_index, out_tag_char, out_distance,
               out_exact_match, out_added, out_table_full};
        if (expected_words.size() == 0) begin
          report_mismatch("word with none expected", 32'd0, 32'(got.index));
        end else begin
          want = expected_words.pop_front();
          if (got.index !== want.index)
            report_mismatch("entry_index", 32'(want.index), 32'(got.index));
          if (got.tag !== want.tag)
            report_mismatch("tag_char", 32'(want.tag), 32'(got.tag));
          if (got.dist_sum !== want.dist_sum)
            report_mismatch("distance", 32'(want.dist_sum), 32'(got.dist_sum));
          if (got.exact !== want.exact)
            report_mismatch("exact_match", 32'(want.exact), 32'(got.exact));
          if (got.added !== want.added)
            report_mismatch("added", 32'(want.added), 32'(got.added));
          if (got.full !== want.full)
            report_mismatch("table_full", 32'(want.full), 32'(got.full));
          words_checked++;
        end
      end
      if (in_valid && in_ready) begin
        predict_lookup(in_color_rgb, want);
        expected_words.push_back(want);
        if (want.added) appended_count++;
        if (want.exact) exact_count++;
        if (want.full) full_count++;
      end
    end
    pending = expected_words.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
// Testbench top: clock, reset, color and threshold stimulus, random stalls and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import pnmi_pkg::*;

  localparam int SEGMENTS = 6;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [RGB_W-1:0]     in_color_rgb = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [IDX_OUT_W-1:0] out_entry_index;
  logic [TAG_W-1:0]     out_tag_char;
  logic [DIST_W-1:0]    out_distance;
  logic                 out_exact_match;
  logic                 out_added;
  logic                 out_table_full;
  logic                 cfg_wr_en = 1'b0;
  logic [DIST_W-1:0]    cfg_wr_data = '0;

  int mismatch_count;
  int pending;
  int words_checked;
  int appended_count;
  int exact_count;
  int full_count;

  int send_idle_pct = 16;
  int recv_idle_pct = 86;
  logic [RGB_W-1:0] sent_colors[$];

  palette_nearest_match_insert_top #(.PALETTE_DEPTH(256)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_color_rgb(in_color_rgb),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_entry_index(out_entry_index),
    .out_tag_char(out_tag_char),
    .out_distance(out_distance),
    .out_exact_match(out_exact_match),
    .out_added(out_added),
    .out_table_full(out_table_full),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  palette_match_checker #(.PALETTE_DEPTH(256)) chk (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_color_rgb(in_color_rgb),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_entry_index(out_entry_index),
    .out_tag_char(out_tag_char),
    .out_distance(out_distance),
    .out_exact_match(out_exact_match),
    .out_added(out_added),
    .out_table_full(out_table_full),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .mismatch_count(mismatch_count),
    .pending(pending),
    .words_checked(words_checked),
    .appended_count(appended_count),
    .exact_count(exact_count),
    .full_count(full_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_color(input logic [RGB_W-1:0] rgb);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_color_rgb <= rgb;
    do @(posedge clk); while (!in_ready);
    sent_colors.push_back(rgb);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [DIST_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] nudge(input logic [7:0] c);
    int v;
    v = int'(c) + int'($urandom_range(8)) - 4;
    if (v < 0) v = 0;
    else if (v > 255) v = 255;
    return 8'(v);
  endfunction

  function automatic logic [RGB_W-1:0] pick_color();
    logic [RGB_W-1:0] base;
    int roll;
    roll = $urandom_range(99);
    if (sent_colors.size() == 0 || roll < 60) return RGB_W'($urandom());
    base = sent_colors[$urandom_range(sent_colors.size() - 1)];
    if (roll < 75) return base;
    return {nudge(base[23:16]), nudge(base[15:8]), nudge(base[7:0])};
  endfunction

  initial begin
    #3000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [DIST_W-1:0] seg_thr[SEGMENTS];
    int                seg_len[SEGMENTS];
    int                seg;
    int                n;
    seg_thr = '{10'd0, 10'd12, 10'd0, 10'h3FF, 10'd40, 10'd765};
    seg_len = '{130, 100, 120, 90, 100, 90};

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // empty palette appends even with the widest threshold
    write_threshold(10'h3FF);
    send_color(24'h000000);
    send_color(24'hFFFFFF);
    send_color(24'h000000);
    settle();
    // tag skips the double quote on the second append
    write_threshold(10'd0);
    send_color(24'hFFFFFF);
    send_color(24'h010203);
    send_color(24'hFFFFFF);
    send_color(24'h000002);
    settle();
    // tie goes to the lower index; exact match wins over an earlier near entry
    write_threshold(10'd1);
    send_color(24'h000001);
    send_color(24'h000002);
    send_color(24'h000004);
    settle();
    write_threshold(10'd2);
    send_color(24'h000004);
    send_color(24'h000007);
    send_color(24'h000009);
    send_color(24'hFF0000);
    send_color(24'h00FF00);
    send_color(24'h0000FF);
    settle();
    write_threshold(10'd765);
    send_color(24'h7F7F7F);
    send_color(24'h808080);
    settle();

    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 2)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_threshold(seg_thr[seg]);
      for (n = 0; n < seg_len[seg]; n++) begin
        send_color(pick_color());
      end
      settle();
    end

    repeat (300) @(negedge clk);
    $display("Covered %0d lookups: %0d appended, %0d exact, %0d against a full palette,",
             words_checked, appended_count, exact_count, full_count);
    $display("thresholds from 0 to 1023 under sender and receiver stalls.");
    if (mismatch_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
